// File: rtl/fiir_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the multichannel first-order IIR filter.
// Depends on nothing; every other file uses it through scoped names.
package fiir_pkg;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int CHAN_W     = 3;
    localparam int FRAC_W     = 5;
    localparam int PROD_W     = 2 * DATA_W;

    // Channel state
    localparam int CHANNELS   = 8;
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Queue between front and back (power of two)
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Back end: product stage, sum stage, output register
    localparam int BACK_SLOTS = 3;
    localparam int MAX_INFLIGHT = QDEPTH + BACK_SLOTS;
    localparam int INFL_W     = $clog2(MAX_INFLIGHT + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0   = 2'd0,
        REG_B1   = 2'd1,
        REG_A1   = 2'd2,
        REG_FRAC = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_b0;
        logic signed [DATA_W-1:0] coef_b1;
        logic signed [DATA_W-1:0] coef_a1;
        logic [FRAC_W-1:0]        frac_bits;
    } t_cfg;

    // One classified request as it sits in the queue
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [CHAN_W-1:0]        chan;
        logic [IDX_W-1:0]         idx;
    } t_item;

    // State slot of a channel number
    function automatic logic [IDX_W-1:0] chan_index(input logic [CHAN_W-1:0] chan);
        return IDX_W'(chan % CHANNELS);
    endfunction

endpackage

// File: rtl/fiir_in_if.sv
`timescale 1ns / 1ps
// Input channel of the IIR filter: valid/ready handshake with sample and channel.
// Depends on fiir_pkg for field widths.
interface fiir_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [fiir_pkg::DATA_W-1:0] sample_in;
    logic [fiir_pkg::CHAN_W-1:0]        chan;

    modport source (output valid, output sample_in, output chan, input ready);
    modport sink   (input valid, input sample_in, input chan, output ready);
endinterface

// File: rtl/fiir_out_if.sv
`timescale 1ns / 1ps
// Output channel of the IIR filter: valid/ready handshake with result and channel.
// Depends on fiir_pkg for field widths.
interface fiir_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fiir_pkg::DATA_W-1:0] sample_out;
    logic [fiir_pkg::CHAN_W-1:0]        chan_out;

    modport source (output valid, output sample_out, output chan_out, input ready);
    modport sink   (input valid, input sample_out, input chan_out, output ready);
endinterface

// File: rtl/fiir_front.sv
`timescale 1ns / 1ps
// Front end: accepts input requests, maps the channel to its state slot and
// queues them for the back end. Depends on fiir_pkg and fiir_in_if.
module fiir_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fiir_in_if.sink               i_in,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output fiir_pkg::t_item       o_q_item
);

    fiir_pkg::t_item                r_entry [fiir_pkg::QDEPTH];
    logic [fiir_pkg::QPTR_W-1:0]    r_wp;
    logic [fiir_pkg::QPTR_W-1:0]    r_rp;
    logic [fiir_pkg::QCNT_W-1:0]    r_cnt;
    logic                           push;
    logic                           pop;
    fiir_pkg::t_item                in_item;

    // Classify the incoming request
    always_comb begin
        in_item.sample = i_in.sample_in;
        in_item.chan   = i_in.chan;
        in_item.idx    = fiir_pkg::chan_index(i_in.chan);
    end

    assign i_in.ready = (r_cnt != fiir_pkg::QCNT_W'(fiir_pkg::QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_item   = r_entry[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (push) r_entry[r_wp] <= in_item;
    end

endmodule

// File: rtl/fiir_back.sv
`timescale 1ns / 1ps
// Back end: issues queued requests, multiplies, sums, scales, updates channel
// state and holds the result. Depends on fiir_pkg and fiir_out_if.
module fiir_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_ready,
    input  fiir_pkg::t_item       i_q_item,
    input  fiir_pkg::t_cfg        i_cfg,
    fiir_out_if.source            o_out
);

    // Channel state
    logic signed [fiir_pkg::DATA_W-1:0] r_xprev [fiir_pkg::CHANNELS];
    logic signed [fiir_pkg::DATA_W-1:0] r_yprev [fiir_pkg::CHANNELS];

    // Product stage
    logic                               r_s1_v;
    logic [fiir_pkg::IDX_W-1:0]         r_s1_idx;
    logic [fiir_pkg::CHAN_W-1:0]        r_s1_chan;
    logic signed [fiir_pkg::PROD_W-1:0] r_s1_p0;
    logic signed [fiir_pkg::PROD_W-1:0] r_s1_p1;
    logic signed [fiir_pkg::PROD_W-1:0] r_s1_p2;

    // Sum stage
    logic                               r_s2_v;
    logic [fiir_pkg::IDX_W-1:0]         r_s2_idx;
    logic [fiir_pkg::CHAN_W-1:0]        r_s2_chan;
    logic signed [fiir_pkg::PROD_W-1:0] r_s2_acc;

    // Output register
    logic                               r_out_v;
    logic signed [fiir_pkg::DATA_W-1:0] r_out_sample;
    logic [fiir_pkg::CHAN_W-1:0]        r_out_chan;

    logic                               adv;
    logic                               hazard;
    logic                               issue;
    logic signed [fiir_pkg::PROD_W-1:0] n_p0;
    logic signed [fiir_pkg::PROD_W-1:0] n_p1;
    logic signed [fiir_pkg::PROD_W-1:0] n_p2;
    logic signed [fiir_pkg::PROD_W-1:0] acc_sh;
    logic signed [fiir_pkg::DATA_W-1:0] y;

    // Pipeline moves when the output slot is free or being drained
    assign adv = !r_out_v || o_out.ready;

    // Hold a request whose channel still has an output in the product or sum stage
    assign hazard = (r_s1_v && (r_s1_idx == i_q_item.idx))
                 || (r_s2_v && (r_s2_idx == i_q_item.idx));
    assign o_q_ready = adv && !hazard;
    assign issue     = i_q_valid && o_q_ready;

    // Three products from the queued sample and the channel's history
    assign n_p0 = i_cfg.coef_b0 * i_q_item.sample;
    assign n_p1 = i_cfg.coef_b1 * r_xprev[i_q_item.idx];
    assign n_p2 = i_cfg.coef_a1 * r_yprev[i_q_item.idx];

    // Scale the sum and wrap to the sample width
    assign acc_sh = r_s2_acc >>> i_cfg.frac_bits;
    assign y      = acc_sh[fiir_pkg::DATA_W-1:0];

    // Valid bits and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < fiir_pkg::CHANNELS; i++) begin
                r_xprev[i] <= '0;
                r_yprev[i] <= '0;
            end
        end else begin
            if (adv) begin
                r_s1_v  <= issue;
                r_s2_v  <= r_s1_v;
                r_out_v <= r_s2_v;
                if (r_s2_v) r_yprev[r_s2_idx] <= y;
            end
            if (issue) r_xprev[i_q_item.idx] <= i_q_item.sample;
        end
    end

    // Payload through the stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx  <= i_q_item.idx;
            r_s1_chan <= i_q_item.chan;
            r_s1_p0   <= n_p0;
            r_s1_p1   <= n_p1;
            r_s1_p2   <= n_p2;

            r_s2_idx  <= r_s1_idx;
            r_s2_chan <= r_s1_chan;
            r_s2_acc  <= r_s1_p0 + r_s1_p1 - r_s1_p2;

            r_out_sample <= y;
            r_out_chan   <= r_s2_chan;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.sample_out = r_out_sample;
    assign o_out.chan_out   = r_out_chan;

endmodule

// File: rtl/first_order_iir_multichannel.sv
`timescale 1ns / 1ps
// Multichannel first-order IIR filter (direct form 1), eight channels of state.
// Each accepted sample yields one output y = (b0*x + b1*x_prev - a1*y_prev) >>> frac_bits,
// wrapped to 32 bits, tagged with its channel, in input order. The block takes one sample
// per cycle while the output is not stalled and no sample shares its channel with either
// of the two samples before it; a sample for a channel whose previous output is still
// in the product or sum stage waits, so a run of samples on one channel is slowed by the
// feedback through those two stages. An accepted sample passes through the queue, the
// product stage and the sum stage into the output register, which holds the result. A
// four-entry queue keeps the input open while the output stalls, until the queue fills.
// Write configuration only while the filter is empty.
module first_order_iir_multichannel (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fiir_in_if.sink                         i_in,
    fiir_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [fiir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fiir_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fiir_pkg::t_cfg  r_cfg;
    logic            q_valid;
    logic            q_ready;
    fiir_pkg::t_item q_item;

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_b0   <= '0;
            r_cfg.coef_b1   <= '0;
            r_cfg.coef_a1   <= '0;
            r_cfg.frac_bits <= fiir_pkg::FRAC_RESET;
        end else if (i_cfg_we) begin
            unique case (fiir_pkg::t_cfg_reg'(i_cfg_idx))
                fiir_pkg::REG_B0:   r_cfg.coef_b0   <= i_cfg_data[fiir_pkg::DATA_W-1:0];
                fiir_pkg::REG_B1:   r_cfg.coef_b1   <= i_cfg_data[fiir_pkg::DATA_W-1:0];
                fiir_pkg::REG_A1:   r_cfg.coef_a1   <= i_cfg_data[fiir_pkg::DATA_W-1:0];
                fiir_pkg::REG_FRAC: r_cfg.frac_bits <= i_cfg_data[fiir_pkg::FRAC_W-1:0];
                default:            r_cfg           <= r_cfg;
            endcase
        end
    end

    fiir_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    fiir_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .i_cfg     (r_cfg),
        .o_out     (o_out)
    );

endmodule

// File: rtl/fiir_check.sv
`timescale 1ns / 1ps
// Port-level checker for the multichannel IIR filter, bound to the top level.
// Depends on fiir_pkg for widths and the in-flight bound.
module fiir_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [fiir_pkg::DATA_W-1:0] i_out_sample,
    input logic [fiir_pkg::CHAN_W-1:0]       i_out_chan
);

    logic [fiir_pkg::INFL_W-1:0] r_inflight;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_chan))
        else $error("output payload changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != '0)
        else $error("output shown with no request outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == fiir_pkg::INFL_W'(fiir_pkg::MAX_INFLIGHT) |-> !i_in_ready)
        else $error("input open with queue and pipeline full");

endmodule

bind first_order_iir_multichannel fiir_check u_fiir_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_chan   (o_out.chan_out)
);

// File: dv/fiir_checker.sv
`timescale 1ns / 1ps
// Checker for the multichannel IIR filter: watches both request channels and the
// register port, predicts each filtered sample and compares in order. Needs fiir_pkg
// and the two channel interfaces.
module fiir_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fiir_in_if                              i_in_mon,
    fiir_out_if                             i_out_mon,
    input  logic                            i_cfg_we,
    input  logic [fiir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fiir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);

    typedef struct packed {
        logic signed [fiir_pkg::DATA_W-1:0] sample;
        logic [fiir_pkg::CHAN_W-1:0]        chan;
    } t_filtered;

    // Filtered samples still owed by the block, oldest first
    t_filtered filtered_q[$];

    // Shadow copy of coefficients and per-channel history
    logic signed [fiir_pkg::DATA_W-1:0] b0;
    logic signed [fiir_pkg::DATA_W-1:0] b1;
    logic signed [fiir_pkg::DATA_W-1:0] a1;
    logic [fiir_pkg::FRAC_W-1:0]        shift;
    logic signed [fiir_pkg::DATA_W-1:0] x_hist [fiir_pkg::CHANNELS];
    logic signed [fiir_pkg::DATA_W-1:0] y_hist [fiir_pkg::CHANNELS];
    int                                 errors;

    // Direct form 1 step: exact sum in a wide accumulator, shift, keep the low word
    function automatic logic signed [fiir_pkg::DATA_W-1:0] iir_output(
        input logic signed [fiir_pkg::DATA_W-1:0] x,
        input logic signed [fiir_pkg::DATA_W-1:0] x_prev,
        input logic signed [fiir_pkg::DATA_W-1:0] y_prev
    );
        logic signed [fiir_pkg::PROD_W+1:0] acc;
        acc = b0 * x + b1 * x_prev - a1 * y_prev;
        acc = acc >>> shift;
        return acc[fiir_pkg::DATA_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_filtered got;
        t_filtered want;
        int        slot;
        if (!i_rst_n) begin
            b0 = '0;
            b1 = '0;
            a1 = '0;
            shift = fiir_pkg::FRAC_RESET;
            for (int i = 0; i < fiir_pkg::CHANNELS; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            filtered_q.delete();
            errors = 0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (fiir_pkg::t_cfg_reg'(i_cfg_idx))
                    fiir_pkg::REG_B0:   b0 = i_cfg_data;
                    fiir_pkg::REG_B1:   b1 = i_cfg_data;
                    fiir_pkg::REG_A1:   a1 = i_cfg_data;
                    fiir_pkg::REG_FRAC: shift = i_cfg_data[fiir_pkg::FRAC_W-1:0];
                    default: ;
                endcase
            end

            // Compare an accepted output request with the oldest prediction
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.sample = i_out_mon.sample_out;
                got.chan   = i_out_mon.chan_out;
                if (filtered_q.size() == 0) begin
                    $error("unexpected output: sample_out=%0d chan_out=%0d",
                           got.sample, got.chan);
                    errors++;
                end else begin
                    want = filtered_q.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d", want.sample, got.sample);
                        errors++;
                    end
                    if (got.chan !== want.chan) begin
                        $error("chan_out: expected %0d, got %0d", want.chan, got.chan);
                        errors++;
                    end
                end
            end

            // Predict the output of an accepted input request and advance history
            if (i_in_mon.valid && i_in_mon.ready) begin
                slot = i_in_mon.chan % fiir_pkg::CHANNELS;
                want.sample = iir_output(i_in_mon.sample_in, x_hist[slot], y_hist[slot]);
                want.chan   = i_in_mon.chan;
                x_hist[slot] = i_in_mon.sample_in;
                y_hist[slot] = want.sample;
                filtered_q.push_back(want);
            end
        end
        o_errors  <= errors;
        o_pending <= filtered_q.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the multichannel IIR filter: clock, reset, register setup,
// sample stimulus, output back-pressure and the verdict. Uses fiir_pkg, the channel
// interfaces, the filter and fiir_checker.
module tb;

    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 80;

    typedef enum int {RUN_SAME, RUN_ROTATE, RUN_SCATTER} t_run_shape;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [fiir_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [fiir_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              errors;
    int                              pending;
    bit                              gaps_on;
    int                              hold_asks;
    int                              hold_served;
    int                              hold_left;
    int                              quiet_cycles;

    fiir_in_if  in_if ();
    fiir_out_if out_if ();

    first_order_iir_multichannel u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fiir_checker u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_mon   (in_if),
        .i_out_mon  (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            out_if.ready <= 1'b0;
            hold_served <= hold_asks;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_if.ready <= !(gaps_on && $urandom_range(99, 0) < 7);
        end
    end

    // Abort when no request moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [fiir_pkg::DATA_W-1:0] rand_sample();
        logic [fiir_pkg::DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(9, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4, 5:    return {{16{r[15]}}, r[15:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [fiir_pkg::DATA_W-1:0] rand_coef();
        logic [fiir_pkg::DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4, 5: return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    // Offer one sample request after an optional random gap; return once accepted
    task automatic send_sample(input logic [fiir_pkg::DATA_W-1:0] value,
                               input logic [fiir_pkg::CHAN_W-1:0] chan);
        while (gaps_on && $urandom_range(99, 0) < 7) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= value;
        in_if.chan      <= chan;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // Drop valid and hold until every predicted output has been taken
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write all four registers back to back; upper bits of the shift word are noise
    task automatic configure(input logic [fiir_pkg::DATA_W-1:0] b0,
                             input logic [fiir_pkg::DATA_W-1:0] b1,
                             input logic [fiir_pkg::DATA_W-1:0] a1,
                             input logic [fiir_pkg::FRAC_W-1:0] frac);
        logic [fiir_pkg::CFG_DATA_W-1:0] frac_word;
        frac_word = $urandom();
        frac_word[fiir_pkg::FRAC_W-1:0] = frac;
        cfg_we   <= 1'b1;
        cfg_idx  <= fiir_pkg::REG_B0;
        cfg_data <= b0;
        @(posedge clk);
        cfg_idx  <= fiir_pkg::REG_B1;
        cfg_data <= b1;
        @(posedge clk);
        cfg_idx  <= fiir_pkg::REG_A1;
        cfg_data <= a1;
        @(posedge clk);
        cfg_idx  <= fiir_pkg::REG_FRAC;
        cfg_data <= frac_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [fiir_pkg::CHAN_W-1:0] chan;
        t_run_shape                  shape;
        int                          run_left;

        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.sample_in <= '0;
        in_if.chan      <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= fiir_pkg::REG_B0;
        cfg_data        <= '0;
        gaps_on         <= 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients give silence whatever goes in
        send_sample(32'h7FFF_FFFF, 3'd0);
        send_sample(32'h8000_0000, 3'd7);
        send_sample(32'h1234_5678, 3'd4);
        wait_drained();

        // Q2.30 filter: extremes, every channel, back-to-back samples on one channel
        configure(32'h4000_0000, 32'h2000_0000, 32'hE000_0000, 5'd30);
        send_sample(32'h7FFF_FFFF, 3'd0);
        send_sample(32'h8000_0000, 3'd0);
        send_sample(32'h0000_0000, 3'd1);
        send_sample(32'hFFFF_FFFF, 3'd1);
        send_sample(32'h0000_0001, 3'd2);
        send_sample(32'h7FFF_FFFF, 3'd3);
        send_sample(32'h7FFF_FFFF, 3'd3);
        send_sample(32'h8000_0000, 3'd3);
        send_sample(32'h1234_5678, 3'd4);
        send_sample(32'h8000_0000, 3'd5);
        send_sample(32'h8000_0000, 3'd5);
        send_sample(32'h7FFF_FFFF, 3'd6);
        send_sample(32'hFFFF_FFFF, 3'd7);
        send_sample(32'hAAAA_AAAA, 3'd7);
        send_sample(32'h5555_5555, 3'd7);

        // Random phases: extreme settings first, then random ones
        chan = '0;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 0) begin
                // Largest coefficients, no shift: the output wraps hard
                configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
            end else if (p == 1) begin
                configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd31);
            end else begin
                configure(rand_coef(), rand_coef(), rand_coef(),
                          fiir_pkg::FRAC_W'($urandom_range(31, 0)));
            end
            gaps_on <= (p != 3);
            run_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mix runs on one channel, rotating channels and scattered ones
                if (run_left == 0) begin
                    run_left = $urandom_range(8, 1);
                    shape = t_run_shape'($urandom_range(RUN_SCATTER, RUN_SAME));
                end
                case (shape)
                    RUN_SAME:   chan = chan;
                    RUN_ROTATE: chan = chan + 1'b1;
                    default:    chan = fiir_pkg::CHAN_W'($urandom_range(7, 0));
                endcase
                run_left--;
                // Fill the block against a stalled output, later let it run dry
                if (p == 2 && n == 10) hold_asks <= hold_asks + 1;
                if (p == 2 && n == 40) wait_drained();
                send_sample(rand_sample(), chan);
            end
        end

        // Drain, let any stray output show up, then give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
